[src/pfda_pkg.sv]
`timescale 1ns / 1ps
// shared types and constants for the pid controller with filtered derivative
// no dependencies
package pfda_pkg;

    // configuration port
    localparam int CFG_IDX_W  = 3;
    localparam int CFG_DATA_W = 32;

    localparam logic [CFG_IDX_W-1:0] REG_GAIN_PROP     = 3'd0;
    localparam logic [CFG_IDX_W-1:0] REG_GAIN_INTEGRAL = 3'd1;
    localparam logic [CFG_IDX_W-1:0] REG_GAIN_DERIV    = 3'd2;
    localparam logic [CFG_IDX_W-1:0] REG_FILTER_TC     = 3'd3;
    localparam logic [CFG_IDX_W-1:0] REG_SAMPLE_PERIOD = 3'd4;
    localparam logic [CFG_IDX_W-1:0] REG_LIMIT_HIGH    = 3'd5;
    localparam logic [CFG_IDX_W-1:0] REG_LIMIT_LOW     = 3'd6;

    localparam logic [31:0]        RST_GAIN_PROP     = 32'd13107;
    localparam logic [31:0]        RST_GAIN_INTEGRAL = 32'd0;
    localparam logic [31:0]        RST_GAIN_DERIV    = 32'd66;
    localparam logic [31:0]        RST_FILTER_TC     = 32'd134218;
    localparam logic [31:0]        RST_SAMPLE_PERIOD = 32'd16777;
    localparam logic signed [15:0] RST_LIMIT_HIGH    = 16'sd255;
    localparam logic signed [15:0] RST_LIMIT_LOW     = -16'sd255;

    // stored signal width and saturation bounds
    localparam int SIG_W = 48;
    localparam logic signed [SIG_W-1:0] SIG_MAX = {1'b0, {(SIG_W-1){1'b1}}};
    localparam logic signed [SIG_W-1:0] SIG_MIN = {1'b1, {(SIG_W-1){1'b0}}};

    // shift-add multiplier and restoring divider
    localparam int MUL_W   = 64;
    localparam int DIV_W   = 64;
    localparam int DEN_W   = 34;
    localparam int MUL_CW  = $clog2(MUL_W);
    localparam int DIV_CW  = $clog2(DIV_W);

    typedef enum logic [2:0] {
        OP_NONE,
        OP_CI,
        OP_P,
        OP_II,
        OP_DA,
        OP_DB,
        OP_T1,
        OP_T2
    } op_t;

    typedef struct packed {
        op_t  op;
        logic start;
        logic load;
        logic fin1;
        logic fin2;
        logic fin3;
    } cmd_t;

    typedef struct packed {
        logic mul_done;
        logic div_done;
        logic out_busy;
    } sts_t;

endpackage

[src/pfda_if.sv]
`timescale 1ns / 1ps
// valid/ready channels: sample input, result output, register writes
// depends on pfda_pkg

interface pfda_in_if;
    logic               valid;
    logic               ready;
    logic [15:0]        target_angle;
    logic signed [39:0] measured_angle;
    modport source (output valid, target_angle, measured_angle, input ready);
    modport sink (input valid, target_angle, measured_angle, output ready);
endinterface

interface pfda_out_if;
    logic               valid;
    logic               ready;
    logic signed [31:0] drive_value;
    modport source (output valid, drive_value, input ready);
    modport sink (input valid, drive_value, output ready);
endinterface

interface pfda_cfg_if;
    import pfda_pkg::*;
    logic                  valid;
    logic                  ready;
    logic [CFG_IDX_W-1:0]  index;
    logic [CFG_DATA_W-1:0] data;
    modport source (output valid, index, data, input ready);
    modport sink (input valid, index, data, output ready);
endinterface

[src/pfda_mul.sv]
`timescale 1ns / 1ps
// unsigned shift-add multiplier, one bit of b per cycle, full product
// depends on pfda_pkg
module pfda_mul
    import pfda_pkg::*;
(
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 start,
    input  logic [MUL_W-1:0]     a,
    input  logic [MUL_W-1:0]     b,
    output logic [2*MUL_W-1:0]   prod,
    output logic                 done
);

    logic              busy_reg;
    logic [MUL_CW-1:0] cnt_reg;
    logic              done_reg;
    logic [MUL_W-1:0]  a_reg;
    logic [MUL_W-1:0]  hi_reg;
    logic [MUL_W-1:0]  lo_reg;
    logic [MUL_W:0]    sum_next;
    logic              last;

    assign last     = (cnt_reg == MUL_CW'(MUL_W - 1));
    assign sum_next = {1'b0, hi_reg} + (lo_reg[0] ? {1'b0, a_reg} : '0);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            cnt_reg  <= '0;
            done_reg <= 1'b0;
        end
        else
        begin
            done_reg <= busy_reg && last;
            if (start)
            begin
                busy_reg <= 1'b1;
                cnt_reg  <= '0;
            end
            else if (busy_reg)
            begin
                cnt_reg <= cnt_reg + 1'b1;
                if (last)
                begin
                    busy_reg <= 1'b0;
                end
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (start)
        begin
            a_reg  <= a;
            hi_reg <= '0;
            lo_reg <= b;
        end
        else if (busy_reg)
        begin
            hi_reg <= sum_next[MUL_W:1];
            lo_reg <= {sum_next[0], lo_reg[MUL_W-1:1]};
        end
    end

    assign prod = {hi_reg, lo_reg};
    assign done = done_reg;

endmodule

[src/pfda_div.sv]
`timescale 1ns / 1ps
// unsigned restoring divider, one quotient bit per cycle
// depends on pfda_pkg
module pfda_div
    import pfda_pkg::*;
(
    input  logic             clk,
    input  logic             rst_n,
    input  logic             start,
    input  logic [DIV_W-1:0] dividend,
    input  logic [DEN_W-1:0] divisor,
    output logic [DIV_W-1:0] quotient,
    output logic             done
);

    logic              busy_reg;
    logic [DIV_CW-1:0] cnt_reg;
    logic              done_reg;
    logic [DEN_W-1:0]  den_reg;
    logic [DEN_W-1:0]  rem_reg;
    logic [DIV_W-1:0]  quo_reg;
    logic [DEN_W:0]    trial;
    logic              last;

    assign last  = (cnt_reg == DIV_CW'(DIV_W - 1));
    assign trial = {rem_reg, quo_reg[DIV_W-1]} - {1'b0, den_reg};

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            cnt_reg  <= '0;
            done_reg <= 1'b0;
        end
        else
        begin
            done_reg <= busy_reg && last;
            if (start)
            begin
                busy_reg <= 1'b1;
                cnt_reg  <= '0;
            end
            else if (busy_reg)
            begin
                cnt_reg <= cnt_reg + 1'b1;
                if (last)
                begin
                    busy_reg <= 1'b0;
                end
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (start)
        begin
            den_reg <= divisor;
            rem_reg <= '0;
            quo_reg <= dividend;
        end
        else if (busy_reg)
        begin
            if (!trial[DEN_W])
            begin
                rem_reg <= trial[DEN_W-1:0];
                quo_reg <= {quo_reg[DIV_W-2:0], 1'b1};
            end
            else
            begin
                rem_reg <= {rem_reg[DEN_W-2:0], quo_reg[DIV_W-1]};
                quo_reg <= {quo_reg[DIV_W-2:0], 1'b0};
            end
        end
    end

    assign quotient = quo_reg;
    assign done     = done_reg;

endmodule

[src/pfda_dp.sv]
`timescale 1ns / 1ps
// datapath: operand latches, shared multiplier and divider, pid state, output register
// depends on pfda_pkg, pfda_mul, pfda_div
module pfda_dp
    import pfda_pkg::*;
(
    input  logic               clk,
    input  logic               rst_n,
    input  cmd_t               cmd,
    output sts_t               sts,
    input  logic [15:0]        target_angle,
    input  logic signed [39:0] measured_angle,
    input  logic [31:0]        gain_prop,
    input  logic [31:0]        gain_integral,
    input  logic [31:0]        gain_deriv,
    input  logic [31:0]        filter_time_const,
    input  logic [31:0]        sample_period,
    input  logic signed [15:0] limit_high,
    input  logic signed [15:0] limit_low,
    output logic               out_valid,
    input  logic               out_ready,
    output logic signed [31:0] drive_value
);

    function automatic logic signed [SIG_W-1:0] sat49(input logic signed [SIG_W:0] v);
        logic signed [SIG_W-1:0] r;
        r = v[SIG_W-1:0];
        if (v[SIG_W] != v[SIG_W-1])
        begin
            r = v[SIG_W] ? SIG_MIN : SIG_MAX;
        end
        return r;
    endfunction

    // pid state
    logic signed [39:0]      last_measured_reg;
    logic signed [40:0]      last_error_reg;
    logic signed [SIG_W-1:0] integrator_reg;
    logic signed [SIG_W-1:0] differentiator_reg;

    // per-sample operands
    logic signed [39:0]      y_reg;
    logic signed [40:0]      err_reg;
    logic signed [41:0]      esum_reg;
    logic signed [40:0]      dy_reg;
    logic [DEN_W-1:0]        den_reg;
    logic [DEN_W-1:0]        anum_reg;
    logic                    aneg_reg;

    // intermediate results
    logic [MUL_W-1:0]        ci_reg;
    logic signed [SIG_W-1:0] p_reg;
    logic signed [SIG_W-1:0] iterm_reg;
    logic [24:0]             ca_reg;
    logic                    caneg_reg;
    logic [MUL_W-1:0]        cb_reg;
    logic signed [SIG_W-1:0] t1_reg;
    logic signed [SIG_W-1:0] t2_reg;
    logic signed [SIG_W-1:0] integ_reg;
    logic signed [SIG_W-1:0] imax_reg;
    logic signed [SIG_W-1:0] imin_reg;
    logic signed [SIG_W-1:0] d_reg;

    logic                    out_valid_reg;
    logic signed [31:0]      drive_reg;

    // load-time arithmetic
    logic signed [40:0]      err_next;
    logic [32:0]             tau2;
    logic signed [34:0]      adiff;

    assign err_next = $signed({9'b0, target_angle, 16'b0}) - 41'(measured_angle);
    assign tau2     = {filter_time_const, 1'b0};
    assign adiff    = $signed({2'b0, tau2}) - $signed({3'b0, sample_period});

    // shared units
    logic [MUL_W-1:0]   mul_a;
    logic [MUL_W-1:0]   mul_b;
    logic [2*MUL_W-1:0] prod;
    logic               mul_done;
    logic               mul_start;
    logic [DIV_W-1:0]   div_num;
    logic [DIV_W-1:0]   quo;
    logic               div_done;
    logic               div_start;

    logic [40:0]        err_mag;
    logic [41:0]        esum_mag;
    logic [40:0]        dy_mag;
    logic [SIG_W-1:0]   dprev_mag;

    assign err_mag   = err_reg[40] ? 41'(-err_reg) : 41'(err_reg);
    assign esum_mag  = esum_reg[41] ? 42'(-esum_reg) : 42'(esum_reg);
    assign dy_mag    = dy_reg[40] ? 41'(-dy_reg) : 41'(dy_reg);
    assign dprev_mag = differentiator_reg[SIG_W-1] ? SIG_W'(-differentiator_reg)
                                                   : SIG_W'(differentiator_reg);

    always_comb
    begin
        mul_a     = '0;
        mul_b     = '0;
        div_num   = '0;
        mul_start = 1'b0;
        div_start = 1'b0;
        case (cmd.op)
            OP_CI:
            begin
                mul_a     = MUL_W'(gain_integral);
                mul_b     = MUL_W'(sample_period);
                mul_start = cmd.start;
            end
            OP_P:
            begin
                mul_a     = MUL_W'(err_mag);
                mul_b     = MUL_W'(gain_prop);
                mul_start = cmd.start;
            end
            OP_II:
            begin
                mul_a     = MUL_W'(esum_mag);
                mul_b     = ci_reg;
                mul_start = cmd.start;
            end
            OP_T1:
            begin
                mul_a     = MUL_W'(dprev_mag);
                mul_b     = MUL_W'(ca_reg);
                mul_start = cmd.start;
            end
            OP_T2:
            begin
                mul_a     = MUL_W'(dy_mag);
                mul_b     = cb_reg;
                mul_start = cmd.start;
            end
            OP_DA:
            begin
                div_num   = DIV_W'({anum_reg, 24'b0});
                div_start = cmd.start;
            end
            OP_DB:
            begin
                div_num   = DIV_W'({gain_deriv, 25'b0});
                div_start = cmd.start;
            end
            default:
            begin
                mul_start = 1'b0;
            end
        endcase
    end

    pfda_mul u_mul (
        .clk   (clk),
        .rst_n (rst_n),
        .start (mul_start),
        .a     (mul_a),
        .b     (mul_b),
        .prod  (prod),
        .done  (mul_done)
    );

    pfda_div u_div (
        .clk      (clk),
        .rst_n    (rst_n),
        .start    (div_start),
        .dividend (div_num),
        .divisor  (den_reg),
        .quotient (quo),
        .done     (div_done)
    );

    // product scaling with magnitude cap
    logic [SIG_W-2:0] m16;
    logic [SIG_W-2:0] m24;
    logic [SIG_W-2:0] m41;

    assign m16 = (|prod[2*MUL_W-1:63]) ? SIG_MAX[SIG_W-2:0] : prod[62:16];
    assign m24 = (|prod[2*MUL_W-1:71]) ? SIG_MAX[SIG_W-2:0] : prod[70:24];
    assign m41 = (|prod[2*MUL_W-1:88]) ? SIG_MAX[SIG_W-2:0] : prod[87:41];

    logic signed [SIG_W-1:0] m16s;
    logic signed [SIG_W-1:0] m24s;
    logic signed [SIG_W-1:0] m41s;

    assign m16s = $signed({1'b0, m16});
    assign m24s = $signed({1'b0, m24});
    assign m41s = $signed({1'b0, m41});

    // finish arithmetic
    logic signed [31:0]      hi_q;
    logic signed [31:0]      lo_q;
    logic signed [SIG_W:0]   isum;
    logic signed [SIG_W:0]   hdiff;
    logic signed [SIG_W:0]   ldiff;
    logic signed [SIG_W:0]   dsum;
    logic signed [SIG_W+1:0] osum;
    logic signed [SIG_W+1:0] osat;

    assign hi_q  = {limit_high, 16'b0};
    assign lo_q  = {limit_low, 16'b0};
    assign isum  = (SIG_W+1)'(integrator_reg) + (SIG_W+1)'(iterm_reg);
    assign hdiff = (SIG_W+1)'(hi_q) - (SIG_W+1)'(p_reg);
    assign ldiff = (SIG_W+1)'(lo_q) - (SIG_W+1)'(p_reg);
    assign dsum  = (SIG_W+1)'(t1_reg) - (SIG_W+1)'(t2_reg);
    assign osum  = (SIG_W+2)'(p_reg) + (SIG_W+2)'(integ_reg) + (SIG_W+2)'(d_reg);

    always_comb
    begin
        osat = osum;
        if (osum > (SIG_W+2)'(hi_q))
        begin
            osat = (SIG_W+2)'(hi_q);
        end
        else if (osum < (SIG_W+2)'(lo_q))
        begin
            osat = (SIG_W+2)'(lo_q);
        end
    end

    // control-free payload registers
    always_ff @(posedge clk)
    begin
        if (cmd.load)
        begin
            y_reg    <= measured_angle;
            err_reg  <= err_next;
            esum_reg <= 42'(err_next) + 42'(last_error_reg);
            dy_reg   <= 41'(measured_angle) - 41'(last_measured_reg);
            den_reg  <= {1'b0, tau2} + {2'b0, sample_period};
            anum_reg <= adiff[34] ? DEN_W'(-adiff) : DEN_W'(adiff);
            aneg_reg <= adiff[34];
        end
        if (mul_done)
        begin
            case (cmd.op)
                OP_CI:   ci_reg    <= prod[MUL_W-1:0];
                OP_P:    p_reg     <= err_reg[40] ? -m16s : m16s;
                OP_II:   iterm_reg <= esum_reg[41] ? -m41s : m41s;
                OP_T1:   t1_reg    <= (differentiator_reg[SIG_W-1] ^ caneg_reg) ? -m24s : m24s;
                OP_T2:   t2_reg    <= dy_reg[40] ? -m16s : m16s;
                default: ci_reg    <= ci_reg;
            endcase
        end
        if (div_done)
        begin
            case (cmd.op)
                OP_DA:
                begin
                    ca_reg    <= (den_reg == '0) ? '0 : quo[24:0];
                    caneg_reg <= aneg_reg && (den_reg != '0);
                end
                OP_DB:   cb_reg <= (den_reg == '0) ? '0 : quo;
                default: cb_reg <= cb_reg;
            endcase
        end
        if (cmd.fin1)
        begin
            integ_reg <= sat49(isum);
            // headroom bounds compared at full signal width
            imax_reg  <= (SIG_W'(hi_q) > p_reg) ? sat49(hdiff) : '0;
            imin_reg  <= (SIG_W'(lo_q) < p_reg) ? sat49(ldiff) : '0;
            d_reg     <= sat49(dsum);
        end
        if (cmd.fin2)
        begin
            if (integ_reg > imax_reg)
            begin
                integ_reg <= imax_reg;
            end
            else if (integ_reg < imin_reg)
            begin
                integ_reg <= imin_reg;
            end
        end
        if (cmd.fin3)
        begin
            drive_reg <= osat[31:0];
        end
    end

    // pid state and output valid
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            last_measured_reg  <= '0;
            last_error_reg     <= '0;
            integrator_reg     <= '0;
            differentiator_reg <= '0;
            out_valid_reg      <= 1'b0;
        end
        else
        begin
            if (cmd.fin2)
            begin
                last_measured_reg  <= y_reg;
                last_error_reg     <= err_reg;
                differentiator_reg <= d_reg;
                if (integ_reg > imax_reg)
                begin
                    integrator_reg <= imax_reg;
                end
                else if (integ_reg < imin_reg)
                begin
                    integrator_reg <= imin_reg;
                end
                else
                begin
                    integrator_reg <= integ_reg;
                end
            end
            if (cmd.fin3)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (out_ready)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    assign out_valid    = out_valid_reg;
    assign drive_value  = drive_reg;
    assign sts.mul_done = mul_done;
    assign sts.div_done = div_done;
    assign sts.out_busy = out_valid_reg && !out_ready;

    a_units_exclusive: assert property (@(posedge clk) disable iff (!rst_n)
        !(mul_done && div_done))
        else $error("multiplier and divider finished together");

    a_integ_in_headroom: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.fin2 |=> (integrator_reg <= $past(imax_reg)) && (integrator_reg >= $past(imin_reg)))
        else $error("integrator outside headroom after clamp");

    a_out_in_limits: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid_reg && $past(cmd.fin3) && limit_low <= limit_high) |->
        (drive_reg <= hi_q) && (drive_reg >= lo_q))
        else $error("drive value outside output limits");

endmodule

[src/pfda_ctrl.sv]
`timescale 1ns / 1ps
// sequencer: walks one sample through the multiply and divide steps
// depends on pfda_pkg
module pfda_ctrl
    import pfda_pkg::*;
(
    input  logic clk,
    input  logic rst_n,
    input  logic in_valid,
    output logic in_ready,
    output cmd_t cmd,
    input  sts_t sts
);

    typedef enum logic [10:0] {
        S_IDLE = 11'b000_0000_0001,
        S_CI   = 11'b000_0000_0010,
        S_P    = 11'b000_0000_0100,
        S_II   = 11'b000_0000_1000,
        S_DA   = 11'b000_0001_0000,
        S_DB   = 11'b000_0010_0000,
        S_T1   = 11'b000_0100_0000,
        S_T2   = 11'b000_1000_0000,
        S_FIN1 = 11'b001_0000_0000,
        S_FIN2 = 11'b010_0000_0000,
        S_FIN3 = 11'b100_0000_0000
    } state_t;

    state_t state_reg;
    state_t state_next;
    logic   launched_reg;
    logic   launched_next;
    logic   done;

    assign done = sts.mul_done || sts.div_done;

    always_comb
    begin
        state_next    = state_reg;
        launched_next = launched_reg;
        cmd           = '0;
        in_ready      = 1'b0;
        case (state_reg)
            S_IDLE:
            begin
                in_ready = 1'b1;
                cmd.load = in_valid;
                if (in_valid)
                begin
                    state_next = S_CI;
                end
            end
            S_CI, S_P, S_II, S_DA, S_DB, S_T1, S_T2:
            begin
                case (state_reg)
                    S_CI:    cmd.op = OP_CI;
                    S_P:     cmd.op = OP_P;
                    S_II:    cmd.op = OP_II;
                    S_DA:    cmd.op = OP_DA;
                    S_DB:    cmd.op = OP_DB;
                    S_T1:    cmd.op = OP_T1;
                    S_T2:    cmd.op = OP_T2;
                    default: cmd.op = OP_NONE;
                endcase
                cmd.start = !launched_reg;
                if (!launched_reg)
                begin
                    launched_next = 1'b1;
                end
                else if (done)
                begin
                    launched_next = 1'b0;
                    case (state_reg)
                        S_CI:    state_next = S_P;
                        S_P:     state_next = S_II;
                        S_II:    state_next = S_DA;
                        S_DA:    state_next = S_DB;
                        S_DB:    state_next = S_T1;
                        S_T1:    state_next = S_T2;
                        default: state_next = S_FIN1;
                    endcase
                end
            end
            S_FIN1:
            begin
                cmd.fin1   = 1'b1;
                state_next = S_FIN2;
            end
            S_FIN2:
            begin
                cmd.fin2   = 1'b1;
                state_next = S_FIN3;
            end
            S_FIN3:
            begin
                if (!sts.out_busy)
                begin
                    cmd.fin3   = 1'b1;
                    state_next = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg    <= S_IDLE;
            launched_reg <= 1'b0;
        end
        else
        begin
            state_reg    <= state_next;
            launched_reg <= launched_next;
        end
    end

    a_single_start: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.start |=> !cmd.start)
        else $error("unit started on two cycles in a row");

    a_done_when_launched: assert property (@(posedge clk) disable iff (!rst_n)
        done |-> launched_reg)
        else $error("unit finished with no step in flight");

    a_no_overwrite: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.fin3 |-> !sts.out_busy)
        else $error("result register written while beat pending");

endmodule

[src/pid_filtered_derivative_antiwindup_unit.sv]
`timescale 1ns / 1ps
// top level of the pid controller: register file, sequencer and datapath
// depends on pfda_pkg, pfda_if, pfda_ctrl, pfda_dp
//
// pid controller with tustin-filtered derivative on the measurement and dynamic
// integrator clamping. each sample beat (target angle, measured angle) gives one
// result beat (saturated drive value, signed q16.16). one sample at a time is
// processed; a sample passes from accept to result through seven steps on a
// shared 64-bit shift-add multiplier and a restoring divider (gain product,
// proportional, integral, two filter coefficients, two derivative terms) and
// then the finishing steps. the next sample is taken while the last result
// still waits in the output register. the user must write registers through the
// config channel (always ready) only while idle; the block does not enforce it.
module pid_filtered_derivative_antiwindup_unit
    import pfda_pkg::*;
(
    input  logic       clk,
    input  logic       rst_n,
    pfda_in_if.sink    sample,
    pfda_out_if.source result,
    pfda_cfg_if.sink   cfg
);

    // configuration registers
    logic [31:0]        gain_prop_reg;
    logic [31:0]        gain_integral_reg;
    logic [31:0]        gain_deriv_reg;
    logic [31:0]        filter_tc_reg;
    logic [31:0]        sample_period_reg;
    logic signed [15:0] limit_high_reg;
    logic signed [15:0] limit_low_reg;

    assign cfg.ready = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            gain_prop_reg     <= RST_GAIN_PROP;
            gain_integral_reg <= RST_GAIN_INTEGRAL;
            gain_deriv_reg    <= RST_GAIN_DERIV;
            filter_tc_reg     <= RST_FILTER_TC;
            sample_period_reg <= RST_SAMPLE_PERIOD;
            limit_high_reg    <= RST_LIMIT_HIGH;
            limit_low_reg     <= RST_LIMIT_LOW;
        end
        else if (cfg.valid)
        begin
            // writes past the last register are dropped
            case (cfg.index)
                REG_GAIN_PROP:     gain_prop_reg     <= cfg.data;
                REG_GAIN_INTEGRAL: gain_integral_reg <= cfg.data;
                REG_GAIN_DERIV:    gain_deriv_reg    <= cfg.data;
                REG_FILTER_TC:     filter_tc_reg     <= cfg.data;
                REG_SAMPLE_PERIOD: sample_period_reg <= cfg.data;
                REG_LIMIT_HIGH:    limit_high_reg    <= cfg.data[15:0];
                REG_LIMIT_LOW:     limit_low_reg     <= cfg.data[15:0];
                default:           limit_low_reg     <= limit_low_reg;
            endcase
        end
    end

    // sequencer to datapath command and status
    cmd_t cmd;
    sts_t sts;

    pfda_ctrl u_ctrl (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (sample.valid),
        .in_ready (sample.ready),
        .cmd      (cmd),
        .sts      (sts)
    );

    pfda_dp u_dp (
        .clk               (clk),
        .rst_n             (rst_n),
        .cmd               (cmd),
        .sts               (sts),
        .target_angle      (sample.target_angle),
        .measured_angle    (sample.measured_angle),
        .gain_prop         (gain_prop_reg),
        .gain_integral     (gain_integral_reg),
        .gain_deriv        (gain_deriv_reg),
        .filter_time_const (filter_tc_reg),
        .sample_period     (sample_period_reg),
        .limit_high        (limit_high_reg),
        .limit_low         (limit_low_reg),
        .out_valid         (result.valid),
        .out_ready         (result.ready),
        .drive_value       (result.drive_value)
    );

endmodule
